[rtl/etfs_pkg.sv]
// Shared constants and types for the encoder tuning frequency stepper.
package etfs_pkg;

  localparam int FreqW = 16;
  localparam int StepW = 10;
  localparam int AddrW = 4;
  localparam int DataW = 32;

  localparam logic [FreqW-1:0] FreqReset = 16'd6400;
  localparam logic [FreqW-1:0] LowReset  = 16'd6400;
  localparam logic [FreqW-1:0] HighReset = 16'd10800;
  localparam logic [StepW-1:0] StepReset = 10'd10;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] RegLowLimit  = 2'd0;
  localparam logic [1:0] RegHighLimit = 2'd1;
  localparam logic [1:0] RegStepSize  = 2'd2;

  typedef struct packed {
    logic [FreqW-1:0] frequency;
    logic             went_up;
  } result_t;

endpackage

[rtl/encoder_tuning_frequency_stepper.sv]
// Channel      | Handshake             | Payload
// in_          | in_valid / in_stall   | in_action, in_display_busy
// out_         | out_valid / out_stall | out_frequency, out_went_up
// cfg (APB)    | psel/penable/pready   | paddr, pwrite, pwdata, prdata
//
// One item per cycle while in_stall is low; the encoder flag and tuning state update at the accept edge.
// A result is registered into the output register, or into the skid entry behind a stalled output.
// A stalled output register backs up into one skid entry; in_stall is high while it is full.
// rst_n is synchronous: limits, step size and the tuned value return to their defaults.
module encoder_tuning_frequency_stepper
  import etfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_action,
  input  logic             in_display_busy,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [FreqW-1:0] out_frequency,
  output logic             out_went_up,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic [FreqW-1:0] low_limit_r;
  logic [FreqW-1:0] high_limit_r;
  logic [StepW-1:0] step_size_r;

  logic [FreqW-1:0] tuned_r, tuned_nxt;
  logic a_exp_r, a_exp_nxt, b_exp_r, b_exp_nxt;
  logic a_fell_r, a_fell_nxt, a_rose_r, a_rose_nxt;
  logic b_fell_r, b_fell_nxt, b_rose_r, b_rose_nxt;

  logic    out_vld_r, skid_vld_r;
  result_t out_r, skid_r, res;
  logic    acc, stepped, res_vld, cfg_wr;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_limit_r  <= LowReset;
      high_limit_r <= HighReset;
      step_size_r  <= StepReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegLowLimit:  low_limit_r  <= pwdata[FreqW-1:0];
        RegHighLimit: high_limit_r <= pwdata[FreqW-1:0];
        RegStepSize:  step_size_r  <= pwdata[StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegLowLimit:  prdata = {{(DataW-FreqW){1'b0}}, low_limit_r};
      RegHighLimit: prdata = {{(DataW-FreqW){1'b0}}, high_limit_r};
      RegStepSize:  prdata = {{(DataW-StepW){1'b0}}, step_size_r};
      default:      prdata = '0;
    endcase
  end

  assign in_stall = skid_vld_r;
  assign acc      = in_valid & ~skid_vld_r;

  always_comb begin
    tuned_nxt  = tuned_r;
    a_exp_nxt  = a_exp_r;
    b_exp_nxt  = b_exp_r;
    a_fell_nxt = a_fell_r;
    a_rose_nxt = a_rose_r;
    b_fell_nxt = b_fell_r;
    b_rose_nxt = b_rose_r;
    stepped    = 1'b0;
    if (!in_action) begin
      if (!a_exp_r) a_fell_nxt = 1'b1;
      else          a_rose_nxt = 1'b1;
      a_exp_nxt = ~a_exp_r;
      if (a_fell_nxt && a_rose_nxt) begin
        a_fell_nxt = 1'b0;
        a_rose_nxt = 1'b0;
        a_exp_nxt  = 1'b0;
        b_exp_nxt  = 1'b0;
        if (b_fell_r) begin
          // b_rose stays as it is on this path
          b_fell_nxt = 1'b0;
          stepped    = 1'b1;
          tuned_nxt  = (tuned_r == low_limit_r) ? high_limit_r
                     : tuned_r - {{(FreqW-StepW){1'b0}}, step_size_r};
        end
      end
    end else begin
      if (!b_exp_r) b_fell_nxt = 1'b1;
      else          b_rose_nxt = 1'b1;
      b_exp_nxt = ~b_exp_r;
      if (b_fell_nxt && b_rose_nxt) begin
        b_fell_nxt = 1'b0;
        b_rose_nxt = 1'b0;
        a_exp_nxt  = 1'b0;
        b_exp_nxt  = 1'b0;
        if (a_fell_r) begin
          a_fell_nxt = 1'b0;
          stepped    = 1'b1;
          tuned_nxt  = (tuned_r == high_limit_r) ? low_limit_r
                     : tuned_r + {{(FreqW-StepW){1'b0}}, step_size_r};
        end
      end
    end
    res.frequency = tuned_nxt;
    res.went_up   = in_action;
  end

  assign res_vld = acc & stepped & ~in_display_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tuned_r  <= FreqReset;
      a_exp_r  <= 1'b0;
      b_exp_r  <= 1'b0;
      a_fell_r <= 1'b0;
      a_rose_r <= 1'b0;
      b_fell_r <= 1'b0;
      b_rose_r <= 1'b0;
    end else if (acc) begin
      tuned_r  <= tuned_nxt;
      a_exp_r  <= a_exp_nxt;
      b_exp_r  <= b_exp_nxt;
      a_fell_r <= a_fell_nxt;
      a_rose_r <= a_rose_nxt;
      b_fell_r <= b_fell_nxt;
      b_rose_r <= b_rose_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || !out_stall) begin
      out_vld_r  <= skid_vld_r | res_vld;
      skid_vld_r <= 1'b0;
    end else if (res_vld) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || !out_stall) begin
      out_r <= skid_vld_r ? skid_r : res;
    end else if (res_vld) begin
      skid_r <= res;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_frequency = out_r.frequency;
  assign out_went_up   = out_r.went_up;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry held with empty output register");

  a_skid_fills: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld && out_vld_r && out_stall |=> skid_vld_r)
    else $error("result behind a stalled output was not kept");

  a_a_expect: assert property (@(posedge clk) disable iff (!rst_n)
    a_exp_r |-> a_fell_r)
    else $error("channel A expects rising without a falling edge seen");

  a_b_expect: assert property (@(posedge clk) disable iff (!rst_n)
    b_exp_r |-> b_fell_r)
    else $error("channel B expects rising without a falling edge seen");

  a_tuned_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(tuned_r))
    else $error("tuned value changed without an accepted item");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for the encoder tuning frequency stepper.
`timescale 1ns / 1ps

module testbench;
  import etfs_pkg::*;

  localparam logic ChanA = 1'b0;
  localparam logic ChanB = 1'b1;
  localparam logic [1:0] RegUnused = 2'd3;
  localparam int WatchdogLimit = 5000;
  localparam int PhaseItems = 120;

  typedef struct packed {
    logic action;
    logic busy;
  } edge_item_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_action = 1'b0;
  logic             in_display_busy = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [FreqW-1:0] out_frequency;
  logic             out_went_up;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  encoder_tuning_frequency_stepper u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_display_busy (in_display_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_frequency   (out_frequency),
    .out_went_up     (out_went_up),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #4 clk = ~clk;

  // shadow registers and tuner state
  logic [FreqW-1:0] lim_low = LowReset;
  logic [FreqW-1:0] lim_high = HighReset;
  logic [StepW-1:0] step_amt = StepReset;
  logic [FreqW-1:0] freq_now = FreqReset;
  logic a_rise_next = 1'b0, b_rise_next = 1'b0;
  logic a_fell_seen = 1'b0, a_rose_seen = 1'b0;
  logic b_fell_seen = 1'b0, b_rose_seen = 1'b0;

  edge_item_t pending_edges[$];
  result_t    expected_freqs[$];
  edge_item_t cur_edge;
  int edges_queued = 0;
  int edges_taken = 0;
  int mismatches = 0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  bit no_idle = 1'b1;

  // advance the tuner by one encoder edge; queue the frequency it reports, if any
  function automatic void step_tuner(input edge_item_t it);
    logic stepped;
    logic up;
    result_t r;
    stepped = 1'b0;
    up = 1'b0;
    if (it.action == ChanA) begin
      if (!a_rise_next) begin
        a_fell_seen = 1'b1;
        a_rise_next = 1'b1;
      end else begin
        a_rose_seen = 1'b1;
        a_rise_next = 1'b0;
      end
      if (a_fell_seen && a_rose_seen) begin
        if (b_fell_seen) begin
          b_fell_seen = 1'b0;
          freq_now = (freq_now == lim_low) ? lim_high : freq_now - 16'(step_amt);
          stepped = 1'b1;
        end
        a_fell_seen = 1'b0;
        a_rose_seen = 1'b0;
        a_rise_next = 1'b0;
        b_rise_next = 1'b0;
      end
    end else begin
      if (!b_rise_next) begin
        b_fell_seen = 1'b1;
        b_rise_next = 1'b1;
      end else begin
        b_rose_seen = 1'b1;
        b_rise_next = 1'b0;
      end
      if (b_fell_seen && b_rose_seen) begin
        if (a_fell_seen) begin
          a_fell_seen = 1'b0;
          freq_now = (freq_now == lim_high) ? lim_low : freq_now + 16'(step_amt);
          stepped = 1'b1;
          up = 1'b1;
        end
        b_fell_seen = 1'b0;
        b_rose_seen = 1'b0;
        a_rise_next = 1'b0;
        b_rise_next = 1'b0;
      end
    end
    if (stepped && !it.busy) begin
      r.frequency = freq_now;
      r.went_up = up;
      expected_freqs.push_back(r);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        step_tuner(cur_edge);
        edges_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_edges.size() != 0) begin
          cur_edge = pending_edges.pop_front();
          in_valid <= 1'b1;
          in_action <= cur_edge.action;
          in_display_busy <= cur_edge.busy;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic note_mismatch(input string msg);
    if (mismatches < 10) $display("%t: %s", $realtime, msg);
    mismatches++;
  endtask

  // monitor: random backpressure and result check
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_freqs.size() == 0) begin
        note_mismatch($sformatf("unexpected result: freq %0d up %0b",
                                out_frequency, out_went_up));
      end else begin
        exp_r = expected_freqs.pop_front();
        if (out_frequency !== exp_r.frequency || out_went_up !== exp_r.went_up)
          note_mismatch($sformatf("expected freq %0d up %0b, got freq %0d up %0b",
                                  exp_r.frequency, exp_r.went_up,
                                  out_frequency, out_went_up));
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog: cycles with no handshake on any port
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog: no progress for %0d cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [DataW-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegLowLimit:  lim_low = data[FreqW-1:0];
      RegHighLimit: lim_high = data[FreqW-1:0];
      RegStepSize:  step_amt = data[StepW-1:0];
      default: ;
    endcase
  endtask

  task automatic push_item(input logic action, input logic busy);
    edge_item_t it;
    it.action = action;
    it.busy = busy;
    pending_edges.push_back(it);
    edges_queued++;
  endtask

  // B falls, then A falls and rises: one detent down
  task automatic push_down(input logic busy);
    push_item(ChanB, 1'($urandom_range(0, 1)));
    push_item(ChanA, 1'($urandom_range(0, 1)));
    push_item(ChanA, busy);
  endtask

  task automatic push_up(input logic busy);
    push_item(ChanA, 1'($urandom_range(0, 1)));
    push_item(ChanB, 1'($urandom_range(0, 1)));
    push_item(ChanB, busy);
  endtask

  task automatic push_quad(input logic first, input logic busy);
    push_item(first, 1'($urandom_range(0, 1)));
    push_item(~first, 1'($urandom_range(0, 1)));
    push_item(first, busy);
    push_item(~first, 1'($urandom_range(0, 1)));
  endtask

  // wait for the sender to drain and every result to arrive
  task automatic wait_idle();
    do @(posedge clk); while (edges_taken != edges_queued || expected_freqs.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int ph;
    int target;
    int r;
    logic [StepW-1:0] st;
    logic [FreqW-1:0] lo;
    logic [FreqW-1:0] hi;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset limits: down from low wraps high, up from high wraps low
    push_down(1'b0);
    push_up(1'b0);
    push_up(1'b0);
    push_down(1'b1);
    push_down(1'b0);
    // lone pairs clear only their own channel's edge flags
    push_item(ChanA, 1'b1);
    push_item(ChanA, 1'b0);
    push_item(ChanB, 1'b0);
    push_item(ChanB, 1'b1);
    push_quad(ChanA, 1'b0);
    push_item(ChanB, 1'b0);
    wait_idle();

    for (ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin
          lo = '0;
          hi = '1;
          st = 10'd1000;
        end
        1: begin
          lo = '1;
          hi = '0;
          st = 10'd1;
        end
        2: begin
          st = '0;
          lo = freq_now;
          hi = FreqW'($urandom);
        end
        3: begin
          st = '1;
          lo = freq_now - 16'(st * 2);
          hi = freq_now + 16'(st * 2);
        end
        default: begin
          st = ($urandom_range(0, 3) == 0) ? StepW'($urandom_range(1, 1000))
                                           : StepW'($urandom_range(1, 20));
          lo = freq_now - 16'(st * $urandom_range(0, 5));
          hi = freq_now + 16'(st * $urandom_range(0, 5));
        end
      endcase
      write_reg(RegLowLimit, ($urandom << FreqW) | lo);
      write_reg(RegHighLimit, ($urandom << FreqW) | hi);
      write_reg(RegStepSize, ($urandom << StepW) | st);
      write_reg(RegUnused, $urandom);
      no_idle = (ph % 4 == 3);

      target = edges_queued + PhaseItems;
      while (edges_queued < target) begin
        r = $urandom_range(0, 9);
        if (r < 3) push_down($urandom_range(0, 3) == 0);
        else if (r < 6) push_up($urandom_range(0, 3) == 0);
        else if (r < 8) push_quad(1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
        else push_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
